FILE: hdl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg: shared types and constants of the length-prefixed frame decoder
// Holds the result kind codes, the queue entry format and the queue size.
// ----------------------------------------------------------------------------
package lpfd_pkg;

   // Kind code of one result.
   typedef enum logic [2:0] {
      KIND_TYPE  = 3'd0,
      KIND_DATA  = 3'd1,
      KIND_EMPTY = 3'd2,
      KIND_OK    = 3'd3,
      KIND_BAD   = 3'd4
   } kind_type;

   // One queue entry: the first result of a byte, plus a flag that asks the
   // back end to follow it with a frame ok result.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value;
      logic        field_last;
      logic        with_ok;
   } op_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int RSP_TDATA_W = 16;

endpackage

FILE: hdl/lpfd_front.sv
// ----------------------------------------------------------------------------
// lpfd_front: byte parser of the length-prefixed frame decoder
// Tracks the frame phase and counters, classifies each byte, queues results.
// ----------------------------------------------------------------------------
module lpfd_front #(
   parameter int LEN_BYTES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [31:0]          csr_data,
   input  logic                 q_full,
   output logic                 push,
   output lpfd_pkg::op_type     push_op
);

   localparam int HDR_W = 8 * LEN_BYTES;
   localparam int CNT_W = (LEN_BYTES > 1) ? $clog2(LEN_BYTES) : 1;
   localparam int CMP_W = (HDR_W > 32) ? HDR_W : 32;

   typedef enum logic [2:0] {
      PH_SIZE = 3'd0,
      PH_TYPE = 3'd1,
      PH_FLEN = 3'd2,
      PH_DATA = 3'd3,
      PH_BAD  = 3'd4
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [HDR_W-1:0]   hdr_ff, hdr_in;
   logic [31:0]        pay_ff, pay_in;
   logic [31:0]        fld_ff, fld_in;
   logic [31:0]        max_ff;

   logic               accept;
   logic [HDR_W-1:0]   hdr_next;
   logic               hdr_last;
   logic [CNT_W-1:0]   cnt_inc;
   logic [31:0]        pay_dec;
   logic [31:0]        fld_dec;
   logic [CMP_W-1:0]   hdr_wide;
   logic [CMP_W-1:0]   max_wide;
   logic [CMP_W-1:0]   pay_wide;

   assign req_tready = !q_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && !q_full;

   assign hdr_next = (hdr_ff << 8) | HDR_W'(req_tdata);
   assign hdr_last = (cnt_ff == CNT_W'(LEN_BYTES - 1));
   assign cnt_inc  = cnt_ff + CNT_W'(1);
   assign pay_dec  = pay_ff - 32'd1;
   assign fld_dec  = fld_ff - 32'd1;
   assign hdr_wide = CMP_W'(hdr_next);
   assign max_wide = CMP_W'(max_ff);
   assign pay_wide = CMP_W'(pay_dec);

   always_comb begin
      phase_in           = phase_ff;
      cnt_in             = cnt_ff;
      hdr_in             = hdr_ff;
      pay_in             = pay_ff;
      fld_in             = fld_ff;
      push               = 1'b0;
      push_op.kind       = lpfd_pkg::KIND_BAD;
      push_op.value      = 8'd0;
      push_op.field_last = 1'b0;
      push_op.with_ok    = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_SIZE: begin
               hdr_in = hdr_next;
               cnt_in = cnt_inc;
               if (hdr_last) begin
                  hdr_in = '0;
                  cnt_in = '0;
                  if (hdr_next == '0 || hdr_wide > max_wide) begin
                     phase_in = PH_BAD;
                     push     = 1'b1;
                  end else begin
                     pay_in   = 32'(hdr_next);
                     phase_in = PH_TYPE;
                  end
               end
            end
            PH_TYPE: begin
               push          = 1'b1;
               push_op.kind  = lpfd_pkg::KIND_TYPE;
               push_op.value = req_tdata;
               pay_in        = pay_dec;
               if (pay_dec == 32'd0) begin
                  push_op.with_ok = 1'b1;
                  phase_in        = PH_SIZE;
               end else begin
                  phase_in = PH_FLEN;
               end
            end
            PH_FLEN: begin
               hdr_in = hdr_next;
               cnt_in = cnt_inc;
               pay_in = pay_dec;
               if (hdr_last) begin
                  hdr_in = '0;
                  cnt_in = '0;
                  if (hdr_wide > pay_wide) begin
                     phase_in = PH_BAD;
                     push     = 1'b1;
                  end else if (hdr_next == '0) begin
                     push               = 1'b1;
                     push_op.kind       = lpfd_pkg::KIND_EMPTY;
                     push_op.field_last = 1'b1;
                     if (pay_dec == 32'd0) begin
                        push_op.with_ok = 1'b1;
                        phase_in        = PH_SIZE;
                     end
                  end else begin
                     fld_in   = 32'(hdr_next);
                     phase_in = PH_DATA;
                  end
               end else if (pay_dec == 32'd0) begin
                  // Payload ran out in the middle of a field length.
                  phase_in = PH_BAD;
                  push     = 1'b1;
               end
            end
            PH_DATA: begin
               fld_in             = fld_dec;
               pay_in             = pay_dec;
               push               = 1'b1;
               push_op.kind       = lpfd_pkg::KIND_DATA;
               push_op.value      = req_tdata;
               push_op.field_last = (fld_dec == 32'd0);
               if (fld_dec == 32'd0) begin
                  if (pay_dec == 32'd0) begin
                     push_op.with_ok = 1'b1;
                     phase_in        = PH_SIZE;
                  end else begin
                     phase_in = PH_FLEN;
                  end
               end
            end
            PH_BAD: begin
               push = 1'b1;
            end
            default: begin
               phase_in = PH_BAD;
               push     = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         cnt_ff   <= '0;
         hdr_ff   <= '0;
         pay_ff   <= '0;
         fld_ff   <= '0;
         max_ff   <= 32'd1048576;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         hdr_ff   <= hdr_in;
         pay_ff   <= pay_in;
         fld_ff   <= fld_in;
         if (csr_valid) begin
            max_ff <= csr_data;
         end
      end
   end

   // Once a frame goes bad the parser never leaves that phase.
   a_bad_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BAD |=> phase_ff == PH_BAD)
      else $error("malformed phase was left");

   // A bad phase on entry always comes with a malformed result.
   a_bad_reported: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_BAD && phase_in == PH_BAD) |->
      (push && push_op.kind == lpfd_pkg::KIND_BAD))
      else $error("entered malformed phase without reporting it");

endmodule

FILE: hdl/lpfd_queue.sv
// ----------------------------------------------------------------------------
// lpfd_queue: small queue between parser and result sender
// Register-based first-in first-out buffer of classified byte results.
// ----------------------------------------------------------------------------
module lpfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lpfd_pkg::op_type   push_op,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output lpfd_pkg::op_type   head
);

   lpfd_pkg::op_type                mem [lpfd_pkg::QUEUE_DEPTH];
   logic [lpfd_pkg::QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [lpfd_pkg::QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [lpfd_pkg::QUEUE_PTR_W:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (lpfd_pkg::QUEUE_PTR_W + 1)'(lpfd_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_op;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from an empty queue");

endmodule

FILE: hdl/lpfd_back.sv
// ----------------------------------------------------------------------------
// lpfd_back: result sender of the length-prefixed frame decoder
// Turns queue entries into one or two results held in an output register.
// ----------------------------------------------------------------------------
module lpfd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                empty,
   input  lpfd_pkg::op_type                    head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lpfd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   logic                 valid_ff;
   logic                 ok_pend_ff;
   lpfd_pkg::kind_type   kind_ff;
   logic [7:0]           value_ff;
   logic                 fl_ff;
   logic                 last_ff;
   logic                 out_free;

   assign out_free = !valid_ff || rsp_tready;
   assign pop      = out_free && !ok_pend_ff && !empty;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(lpfd_pkg::RSP_TDATA_W - 11){1'b0}}, value_ff, kind_ff};
   assign rsp_tuser  = fl_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         ok_pend_ff <= 1'b0;
         kind_ff    <= lpfd_pkg::KIND_TYPE;
         value_ff   <= 8'd0;
         fl_ff      <= 1'b0;
         last_ff    <= 1'b0;
      end else if (out_free) begin
         if (ok_pend_ff) begin
            valid_ff   <= 1'b1;
            ok_pend_ff <= 1'b0;
            kind_ff    <= lpfd_pkg::KIND_OK;
            value_ff   <= 8'd0;
            fl_ff      <= 1'b0;
            last_ff    <= 1'b1;
         end else if (!empty) begin
            valid_ff   <= 1'b1;
            ok_pend_ff <= head.with_ok;
            kind_ff    <= head.kind;
            value_ff   <= head.value;
            fl_ff      <= head.field_last;
            last_ff    <= !head.with_ok;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   // A pending frame ok always sits behind a result still on the output.
   a_ok_behind_result: assert property (@(posedge clock) disable iff (reset)
      ok_pend_ff |-> (valid_ff && !last_ff))
      else $error("frame ok pending without a shown first result");

   // Frame ok and malformed are always the last result of their byte.
   a_end_kinds_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (kind_ff == lpfd_pkg::KIND_OK || kind_ff == lpfd_pkg::KIND_BAD))
      |-> last_ff)
      else $error("closing result not marked last of its byte");

endmodule

FILE: hdl/length_prefixed_frame_decoder.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder: streaming length-prefixed TLV deframer
// Parses a byte stream of size-prefixed frames into tagged result transfers.
// ----------------------------------------------------------------------------
// The decoder takes one received byte per req transfer and can accept a new
// byte in every clock cycle. A frame is a LEN_BYTES big-endian payload size,
// a type byte, then fields, each a LEN_BYTES big-endian length followed by
// that many data bytes. Each byte causes zero, one or two rsp transfers, each
// carrying a kind (type byte, field data byte, empty field, frame ok or
// malformed), the byte value, a field-last flag in tuser, and tlast on the
// last result caused by that byte. Bytes are reported as they arrive, so a
// consumer must drop a frame that ends in a malformed result; malformed is
// sticky until reset. The front parser decides each byte's results in the
// cycle it is accepted and writes them into a four-entry queue; the back end
// moves one result per cycle into the output register whenever that register
// is free. The first result of a byte passes through its queue entry and then
// the output register before it is shown on rsp. Sustained input rate is one
// byte per cycle as long as rsp_tready stays high; the last byte of a frame
// needs two results (its result plus frame ok), which the queue absorbs, and
// req_tready drops only when the queue fills. The csr channel writes
// max_payload and is always ready; write it only while the decoder is idle.
// ----------------------------------------------------------------------------
module length_prefixed_frame_decoder #(
   parameter int LEN_BYTES = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input byte stream. tdata: in_byte[7:0].
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,
   // Result stream. tdata: kind[2:0], value[10:3], zero fill [15:11].
   // tuser: field_last. tlast: last result caused by the input byte.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lpfd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   // Configuration write: max_payload, the largest payload size in bytes.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [31:0]                       csr_data
);

   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   lpfd_pkg::op_type   q_push_op;
   lpfd_pkg::op_type   q_head;

   // Front: consumes bytes, tracks the frame phase and length counters.
   lpfd_front #(
      .LEN_BYTES (LEN_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .push       (q_push),
      .push_op    (q_push_op)
   );

   // Queue: lets the parser keep taking bytes while the output is stalled
   // or busy sending the second result of a frame's last byte.
   lpfd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .head    (q_head)
   );

   // Back: expands each entry into its results on the rsp channel.
   lpfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the length-prefixed frame decoder
// Feeds size-prefixed frames byte by byte, predicts every result transfer and
// checks each one field by field, with random idling on both streams.
// ----------------------------------------------------------------------------
// The run starts with a short directed table of frames and then builds random
// well-formed frames under several max_payload settings. One phase holds the
// result stream off for a long stretch so that the internal queue fills and
// req_tready drops. Malformed is sticky until reset, and reset is asserted only
// once, so a single broken frame closes the run and is followed by noise bytes
// that must each produce a malformed result.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HDR_BYTES     = 4;
   localparam int          MAX_GAP       = 17;
   localparam int          HOLD_CYCLES   = 150;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          LIMIT_CYCLES  = 500000;
   localparam logic [31:0] RESET_MAX     = 32'd1048576;

   // Parser position inside the byte stream.
   typedef enum logic [2:0] {
      ST_SIZE, ST_TYPE, ST_FLEN, ST_DATA, ST_BAD
   } parse_state_type;

   // The kind of damage done to the frame that closes the run.
   typedef enum logic [2:0] {
      BREAK_SIZE_ZERO, BREAK_SIZE_HIGH, BREAK_SHORT_LENGTH, BREAK_LONG_FIELD,
      BREAK_LIMIT_ZERO
   } broken_frame_type;

   typedef struct packed {
      lpfd_pkg::kind_type kind;
      logic [7:0]         value;
      logic               field_last;
      logic               run_last;
   } frame_result_type;

   // One row of the directed table. n_typed < 0 means the predictor decides.
   typedef struct {
      logic [7:0]       b;
      int               n_typed;
      frame_result_type r0;
      frame_result_type r1;
   } stim_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata = 8'h00;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [lpfd_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [31:0]                      csr_data = 32'h0;

   // Predictor state, mirrors the decoder after reset.
   parse_state_type st = ST_SIZE;
   int              hdr_count = 0;
   logic [31:0]     hdr_shift = '0;
   logic [31:0]     pay_left = '0;
   logic [31:0]     fld_left = '0;
   logic [31:0]     max_payload_cfg = RESET_MAX;

   frame_result_type step_results[$];
   frame_result_type expected_results[$];
   stim_row_type     stim_table[$];
   logic [7:0]       frame_bytes[$];

   int            mismatch_count = 0;
   int            cycle_count = 0;
   bit            tx_fast = 1'b0;
   bit            rx_fast = 1'b0;
   bit            hold_req = 1'b0;

   length_prefixed_frame_decoder #(.LEN_BYTES(HDR_BYTES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("length_prefixed_frame_decoder test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic frame_result_type mk_result(lpfd_pkg::kind_type k, logic [7:0] v,
                                                  logic fl, logic rl);
      frame_result_type r;
      r.kind       = k;
      r.value      = v;
      r.field_last = fl;
      r.run_last   = rl;
      return r;
   endfunction

   function automatic void add_result(lpfd_pkg::kind_type k, logic [7:0] v, logic fl);
      step_results = {step_results, mk_result(k, v, fl, 1'b0)};
   endfunction

   // A field or the type byte just closed: either the payload is used up and
   // the frame is good, or another field length follows.
   function automatic void close_field_or_frame();
      if (pay_left == 0) begin
         add_result(lpfd_pkg::KIND_OK, 8'h00, 1'b0);
         st = ST_SIZE;
      end else begin
         st = ST_FLEN;
      end
      hdr_count = 0;
      hdr_shift = '0;
   endfunction

   function automatic void go_malformed();
      st = ST_BAD;
      add_result(lpfd_pkg::KIND_BAD, 8'h00, 1'b0);
   endfunction

   // Works out the results that one accepted byte causes, in step_results.
   function automatic void decode_byte(logic [7:0] b);
      logic [31:0] flen;
      step_results.delete();
      case (st)
         ST_SIZE: begin
            hdr_shift = (hdr_shift << 8) | 32'(b);
            hdr_count++;
            if (hdr_count >= HDR_BYTES) begin
               hdr_count = 0;
               if (hdr_shift == 0 || hdr_shift > max_payload_cfg) begin
                  go_malformed();
               end else begin
                  pay_left = hdr_shift;
                  st = ST_TYPE;
               end
               hdr_shift = '0;
            end
         end
         ST_TYPE: begin
            add_result(lpfd_pkg::KIND_TYPE, b, 1'b0);
            pay_left--;
            close_field_or_frame();
         end
         ST_FLEN: begin
            hdr_shift = (hdr_shift << 8) | 32'(b);
            hdr_count++;
            pay_left--;
            if (hdr_count >= HDR_BYTES) begin
               flen = hdr_shift;
               hdr_count = 0;
               hdr_shift = '0;
               if (flen > pay_left) begin
                  go_malformed();
               end else if (flen == 0) begin
                  add_result(lpfd_pkg::KIND_EMPTY, 8'h00, 1'b1);
                  close_field_or_frame();
               end else begin
                  fld_left = flen;
                  st = ST_DATA;
               end
            end else if (pay_left == 0) begin
               // The payload ran out in the middle of a field length.
               go_malformed();
            end
         end
         ST_DATA: begin
            fld_left--;
            pay_left--;
            add_result(lpfd_pkg::KIND_DATA, b, fld_left == 0);
            if (fld_left == 0) close_field_or_frame();
         end
         default: begin
            go_malformed();
         end
      endcase
      if (step_results.size() > 0) begin
         step_results[step_results.size() - 1].run_last = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Frame builders
   // ------------------------------------------------------------------------
   function automatic void add_row(logic [7:0] b, int n, frame_result_type r0,
                                   frame_result_type r1);
      stim_row_type row;
      row.b       = b;
      row.n_typed = n;
      row.r0      = r0;
      row.r1      = r1;
      stim_table  = {stim_table, row};
   endfunction

   function automatic void push_be(logic [31:0] v);
      for (int i = HDR_BYTES - 1; i >= 0; i--) frame_bytes = {frame_bytes, v[8*i +: 8]};
   endfunction

   function automatic void add_random_byte();
      frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
   endfunction

   // Builds one well-formed frame whose payload fits the given limit. Most
   // fields are short; now and then a longer one, or a frame that is exactly
   // as large as the limit allows.
   function automatic void build_frame(logic [31:0] limit);
      int unsigned lens[$];
      int unsigned total;
      int unsigned len;
      int unsigned nf;
      frame_bytes.delete();
      total = 1;
      if (limit >= 5 && limit <= 200 && $urandom_range(0, 7) == 0) begin
         lens  = {lens, limit - 32'd5};
         total = limit;
      end else if (limit >= 5) begin
         nf = $urandom_range(0, 4);
         for (int i = 0; i < nf; i++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
            if (total + 4 + len <= limit) begin
               lens  = {lens, len};
               total += 4 + len;
            end
         end
      end
      push_be(total);
      add_random_byte();
      foreach (lens[i]) begin
         push_be(lens[i]);
         for (int j = 0; j < lens[i]; j++) add_random_byte();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driving tasks. Inputs change at the falling edge; handshakes are judged
   // at the rising edge.
   // ------------------------------------------------------------------------
   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_predicted(logic [7:0] b);
      send_byte(b);
      decode_byte(b);
      expected_results = {expected_results, step_results};
   endtask

   task automatic send_frames(int target);
      int sent;
      sent = 0;
      while (sent < target) begin
         build_frame(max_payload_cfg);
         foreach (frame_bytes[i]) send_predicted(frame_bytes[i]);
         sent += frame_bytes.size();
      end
   endtask

   // Stops offering bytes and lets every expected result come out. Header
   // bytes cause no result, so a few more cycles pass before the decoder is
   // treated as idle.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_payload(logic [31:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      max_payload_cfg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s got %0h expected %0h",
               cycle_count, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Result receiver: draws a stall before every transfer, and on request
   // holds tready low for a long stretch so the decoder backs up.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int               wait_cycles;
      frame_result_type want;
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
         if (hold_req) begin
            wait_cycles = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         @(negedge clock);
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, tdata", rsp_tdata, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[2:0] !== want.kind)
               report_mismatch("kind", rsp_tdata[2:0], want.kind);
            if (rsp_tdata[10:3] !== want.value)
               report_mismatch("value", rsp_tdata[10:3], want.value);
            if (rsp_tdata[15:11] !== 5'd0)
               report_mismatch("tdata fill", rsp_tdata[15:11], 0);
            if (rsp_tuser !== want.field_last)
               report_mismatch("field_last", rsp_tuser, want.field_last);
            if (rsp_tlast !== want.run_last)
               report_mismatch("tlast", rsp_tlast, want.run_last);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      frame_result_type none;
      broken_frame_type damage;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. Rows with a typed count carry results that follow
      // directly from the frame format; the rest go through the predictor.
      none = mk_result(lpfd_pkg::KIND_TYPE, 8'h00, 1'b0, 1'b0);
      // Smallest frame: size 1, type byte only, which also closes the frame.
      add_row(8'h00, 0, none, none);
      add_row(8'h00, 0, none, none);
      add_row(8'h00, 0, none, none);
      add_row(8'h01, 0, none, none);
      add_row(8'hFF, 2, mk_result(lpfd_pkg::KIND_TYPE, 8'hFF, 1'b0, 1'b0),
              mk_result(lpfd_pkg::KIND_OK, 8'h00, 1'b0, 1'b1));
      // Size 5: type byte and one empty field that ends the frame.
      add_row(8'h00, 0, none, none);
      add_row(8'h00, 0, none, none);
      add_row(8'h00, 0, none, none);
      add_row(8'h05, 0, none, none);
      add_row(8'h00, 1, mk_result(lpfd_pkg::KIND_TYPE, 8'h00, 1'b0, 1'b1), none);
      add_row(8'h00, 0, none, none);
      add_row(8'h00, 0, none, none);
      add_row(8'h00, 0, none, none);
      add_row(8'h00, 2, mk_result(lpfd_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b0),
              mk_result(lpfd_pkg::KIND_OK, 8'h00, 1'b0, 1'b1));
      // Size 7: type byte and one two-byte field.
      add_row(8'h00, 0, none, none);
      add_row(8'h00, 0, none, none);
      add_row(8'h00, 0, none, none);
      add_row(8'h07, 0, none, none);
      add_row(8'hA5, -1, none, none);
      add_row(8'h00, -1, none, none);
      add_row(8'h00, -1, none, none);
      add_row(8'h00, -1, none, none);
      add_row(8'h02, -1, none, none);
      add_row(8'h80, 1, mk_result(lpfd_pkg::KIND_DATA, 8'h80, 1'b0, 1'b1), none);
      add_row(8'h7F, 2, mk_result(lpfd_pkg::KIND_DATA, 8'h7F, 1'b1, 1'b0),
              mk_result(lpfd_pkg::KIND_OK, 8'h00, 1'b0, 1'b1));

      foreach (stim_table[i]) begin
         send_byte(stim_table[i].b);
         decode_byte(stim_table[i].b);
         if (stim_table[i].n_typed < 0) begin
            expected_results = {expected_results, step_results};
         end else begin
            if (stim_table[i].n_typed > 0)
               expected_results = {expected_results, stim_table[i].r0};
            if (stim_table[i].n_typed > 1)
               expected_results = {expected_results, stim_table[i].r1};
         end
      end

      // Random frames under the reset limit.
      send_frames(400);

      // The receiver stalls for a long stretch while bytes keep coming back
      // to back, so the queue fills and the input stalls.
      hold_req = 1'b1;
      tx_fast  = 1'b1;
      send_frames(60);
      tx_fast  = 1'b0;
      drain();

      // Lowest limit: only type-only frames fit.
      write_max_payload(32'd1);
      send_frames(150);
      drain();

      // Highest limit, with both streams running without idle cycles.
      write_max_payload(32'hFFFF_FFFF);
      tx_fast = 1'b1;
      rx_fast = 1'b1;
      send_frames(400);
      tx_fast = 1'b0;
      rx_fast = 1'b0;
      drain();

      // A small limit, so frames of exactly the limit show up often.
      write_max_payload($urandom_range(5, 60));
      send_frames(400);
      drain();

      write_max_payload(RESET_MAX);
      send_frames(200);
      drain();

      // One broken frame ends the well-formed traffic: malformed is sticky,
      // so every later byte must report malformed as well.
      damage = broken_frame_type'($urandom_range(0, 4));
      frame_bytes.delete();
      case (damage)
         BREAK_SIZE_ZERO: begin
            push_be(32'd0);
         end
         BREAK_SIZE_HIGH: begin
            push_be(max_payload_cfg + 1);
         end
         BREAK_SHORT_LENGTH: begin
            // Payload of 3 ends after two bytes of the field length.
            push_be(32'd3);
            add_random_byte();
            add_random_byte();
            add_random_byte();
         end
         BREAK_LONG_FIELD: begin
            // Only two payload bytes remain after the field length.
            push_be(32'd7);
            add_random_byte();
            push_be($urandom_range(3, 255));
         end
         default: begin
            // A zero limit turns down every size.
            write_max_payload(32'd0);
            push_be(32'd1);
         end
      endcase
      for (int i = 0; i < 40; i++) add_random_byte();
      foreach (frame_bytes[i]) send_predicted(frame_bytes[i]);
      drain();

      if (mismatch_count == 0) begin
         $display("length_prefixed_frame_decoder test passed");
      end else begin
         $display("length_prefixed_frame_decoder test failed");
      end
      $finish;
   end

endmodule

FILE: length_prefixed_frame_decoder.f
hdl/lpfd_pkg.sv
hdl/lpfd_front.sv
hdl/lpfd_queue.sv
hdl/lpfd_back.sv
hdl/length_prefixed_frame_decoder.sv
test/tb_top.sv
